// ----- hdl/ltd_pkg.sv -----
package ltd_pkg;

	localparam int SampleW = 16;
	localparam int FracW = 16;
	localparam int AvgW = 32;
	localparam int AvgShift = 5;
	localparam int DeltaW = 33;
	localparam int LevelW = 48;
	localparam int LeakW = 16;
	localparam int CfgDataW = 64;
	localparam int CfgAddrW = 5;

	localparam logic [1:0] REG_DIFF_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_PRESS_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_LEAK_PRESSED = 2'd2;
	localparam logic [1:0] REG_LEAK_RELEASED = 2'd3;

	localparam logic [31:0] DIFF_THRESHOLD_RST = 32'd655;
	localparam logic signed [LevelW-1:0] PRESS_THRESHOLD_RST = 48'sd65536;
	localparam logic [LeakW-1:0] LEAK_PRESSED_RST = 16'd58982;
	localparam logic [LeakW-1:0] LEAK_RELEASED_RST = 16'd58982;

	typedef struct packed {
		logic [31:0] diff_threshold;
		logic signed [LevelW-1:0] press_threshold;
		logic [LeakW-1:0] leak_pressed;
		logic [LeakW-1:0] leak_released;
	} cfg_t;

endpackage

// ----- hdl/leaky_integrator_touch_detector_top.sv -----
// Touch detector for a stream of 16-bit capacitance samples. Each sample beat
// yields exactly one result beat carrying the pressed flag, the change of the
// 1/32 exponential average and the saturated integrator level before leak.
// The block sustains one sample per clock cycle unless the output stalls; each
// result passes the input register, average stage and output register. The rate
// is set by the integrator loop, where the add, saturation, threshold compare and
// 48 x 16 leak multiply are combinational. The user must write registers over the
// configuration port only while the stream is idle; the block does not enforce it.
module leaky_integrator_touch_detector_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // sample[15:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // avg_delta[32:0], integrator_level[80:33], zero pad
	output logic [0:0]  m_tuser,  // pressed
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [ltd_pkg::CfgAddrW-1:0] paddr,
	input  logic [ltd_pkg::CfgDataW-1:0] pwdata,
	output logic [ltd_pkg::CfgDataW-1:0] prdata,
	output logic        pready
);

	ltd_pkg::cfg_t cfg_q;

	logic valid_s1, valid_s2, out_valid_q;
	logic en1, en2, en3;
	logic [ltd_pkg::SampleW-1:0] sample_s1;
	logic [ltd_pkg::AvgW-1:0] avg_q;
	logic seeded_q;
	logic signed [ltd_pkg::LevelW-1:0] leaked_q;

	logic [ltd_pkg::AvgW-1:0] target, base, new_avg;
	logic signed [ltd_pkg::DeltaW-1:0] gap, step, mag;
	logic integ;

	logic signed [ltd_pkg::DeltaW-1:0] diff_s2;
	logic integ_s2;

	logic signed [ltd_pkg::LevelW:0] sum;
	logic signed [ltd_pkg::LevelW-1:0] level;
	logic pressed;
	logic [ltd_pkg::LeakW-1:0] leak;
	logic signed [ltd_pkg::LevelW+ltd_pkg::LeakW:0] prod;

	logic pressed_q;
	logic signed [ltd_pkg::DeltaW-1:0] delta_q;
	logic signed [ltd_pkg::LevelW-1:0] level_q;

	logic cfg_wr;
	logic [1:0] cfg_idx;

	// config port
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = paddr[ltd_pkg::CfgAddrW-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.diff_threshold <= ltd_pkg::DIFF_THRESHOLD_RST;
			cfg_q.press_threshold <= ltd_pkg::PRESS_THRESHOLD_RST;
			cfg_q.leak_pressed <= ltd_pkg::LEAK_PRESSED_RST;
			cfg_q.leak_released <= ltd_pkg::LEAK_RELEASED_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				ltd_pkg::REG_DIFF_THRESHOLD: cfg_q.diff_threshold <= pwdata[31:0];
				ltd_pkg::REG_PRESS_THRESHOLD:
					cfg_q.press_threshold <= pwdata[ltd_pkg::LevelW-1:0];
				ltd_pkg::REG_LEAK_PRESSED: cfg_q.leak_pressed <= pwdata[ltd_pkg::LeakW-1:0];
				ltd_pkg::REG_LEAK_RELEASED: cfg_q.leak_released <= pwdata[ltd_pkg::LeakW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			ltd_pkg::REG_DIFF_THRESHOLD: prdata = {32'd0, cfg_q.diff_threshold};
			ltd_pkg::REG_PRESS_THRESHOLD: prdata = {16'd0, cfg_q.press_threshold};
			ltd_pkg::REG_LEAK_PRESSED: prdata = {48'd0, cfg_q.leak_pressed};
			ltd_pkg::REG_LEAK_RELEASED: prdata = {48'd0, cfg_q.leak_released};
			default: prdata = '0;
		endcase
	end

	// stage enables
	assign en3 = !out_valid_q || m_tready;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign s_tready = en1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && s_tvalid) begin
			sample_s1 <= s_tdata;
		end
	end

	// average update; the previous average is the stored one once seeded, else the first sample
	assign target = {sample_s1, {ltd_pkg::FracW{1'b0}}};
	assign base = seeded_q ? avg_q : target;
	assign gap = $signed({1'b0, target}) - $signed({1'b0, base});
	assign step = gap >>> ltd_pkg::AvgShift;
	assign new_avg = base + step[ltd_pkg::AvgW-1:0];
	assign mag = step[ltd_pkg::DeltaW-1] ? -step : step;
	assign integ = $unsigned(mag) > {1'b0, cfg_q.diff_threshold};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= '0;
			seeded_q <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (valid_s1 && en2) begin
				avg_q <= new_avg;
				seeded_q <= 1'b1;
			end
			if (en2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			diff_s2 <= step;
			integ_s2 <= integ;
		end
	end

	// integrator, saturation, press decision and leak
	always_comb begin
		sum = {leaked_q[ltd_pkg::LevelW-1], leaked_q};
		if (integ_s2) begin
			sum = sum + {{(ltd_pkg::LevelW + 1 - ltd_pkg::DeltaW){diff_s2[ltd_pkg::DeltaW-1]}},
				diff_s2};
		end
		if (sum[ltd_pkg::LevelW] != sum[ltd_pkg::LevelW-1]) begin
			level = sum[ltd_pkg::LevelW] ? {1'b1, {(ltd_pkg::LevelW-1){1'b0}}}
				: {1'b0, {(ltd_pkg::LevelW-1){1'b1}}};
		end else begin
			level = sum[ltd_pkg::LevelW-1:0];
		end
		pressed = level >= cfg_q.press_threshold;
		leak = pressed ? cfg_q.leak_pressed : cfg_q.leak_released;
		prod = level * $signed({1'b0, leak});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			leaked_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (valid_s2 && en3) begin
				leaked_q <= prod[ltd_pkg::LevelW+ltd_pkg::FracW-1:ltd_pkg::FracW];
			end
			if (en3) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			pressed_q <= pressed;
			delta_q <= diff_s2;
			level_q <= level;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser = pressed_q;
	assign m_tdata = {7'd0, level_q, delta_q};

	// average stays inside the sample range
	a_avg_range: assert property (@(posedge clk) disable iff (!arst_n)
		seeded_q |-> avg_q <= 32'hFFFF0000)
		else $error("average out of range");

	// leak never grows a non-negative level nor flips its sign
	a_leak_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && en3 && !level[ltd_pkg::LevelW-1])
		|=> (!leaked_q[ltd_pkg::LevelW-1] && leaked_q <= $past(level)))
		else $error("leak increased integrator");

	// a full pipe behind a stalled output takes no new beat
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready && valid_s1 && valid_s2) |-> !s_tready)
		else $error("beat accepted into full pipeline");

endmodule

// ----- bench/leaky_integrator_touch_detector_top_tb.sv -----
`timescale 1ns / 1ps

module leaky_integrator_touch_detector_top_tb;

	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles = 8;
	localparam int HoldCycles = 300;
	localparam longint LevelMax = 64'sd140737488355327;
	localparam longint LevelMin = -64'sd140737488355328;

	typedef struct {
		logic pressed;
		logic [ltd_pkg::DeltaW-1:0] avg_delta;
		logic [ltd_pkg::LevelW-1:0] level;
	} touch_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [87:0] m_tdata;
	logic [0:0] m_tuser;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ltd_pkg::CfgAddrW-1:0] paddr = '0;
	logic [ltd_pkg::CfgDataW-1:0] pwdata = '0;
	logic [ltd_pkg::CfgDataW-1:0] prdata;
	logic pready;

	// predictor state and register copy
	ltd_pkg::cfg_t touch_cfg;
	longint avg_now;
	longint avg_prev;
	longint integ_leaked;
	bit seeded;

	touch_result_t touch_results_due[$];
	int mismatches = 0;
	int idle_cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_req = 0;
	int hold_left = 0;

	leaky_integrator_touch_detector_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic touch_result_t predict_touch(logic [15:0] sample);
		touch_result_t r;
		longint target;
		longint diff;
		longint mag;
		longint level;
		longint thr;
		logic [ltd_pkg::LeakW-1:0] leak;
		target = longint'(sample) <<< ltd_pkg::FracW;
		if (!seeded) begin
			avg_now = target;
			avg_prev = target;
			seeded = 1;
		end
		avg_now = avg_now + ((target - avg_now) >>> ltd_pkg::AvgShift);
		diff = avg_now - avg_prev;
		avg_prev = avg_now;
		mag = (diff < 0) ? -diff : diff;
		level = integ_leaked;
		if (mag > longint'(touch_cfg.diff_threshold)) begin
			level = level + diff;
			if (level > LevelMax)
				level = LevelMax;
			if (level < LevelMin)
				level = LevelMin;
		end
		thr = {{16{touch_cfg.press_threshold[ltd_pkg::LevelW-1]}}, touch_cfg.press_threshold};
		r.pressed = (level >= thr);
		leak = r.pressed ? touch_cfg.leak_pressed : touch_cfg.leak_released;
		integ_leaked = (level * longint'(leak)) >>> ltd_pkg::FracW;
		r.avg_delta = diff[ltd_pkg::DeltaW-1:0];
		r.level = level[ltd_pkg::LevelW-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on %s: got %h, want %h", what, got, want);
		mismatches++;
	endtask

	task automatic send_sample(input logic [15:0] sample);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= sample;
		do @(posedge clk); while (!s_tready);
		touch_results_due.push_back(predict_touch(sample));
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (touch_results_due.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ltd_pkg::REG_DIFF_THRESHOLD: touch_cfg.diff_threshold = value[31:0];
			ltd_pkg::REG_PRESS_THRESHOLD:
				touch_cfg.press_threshold = value[ltd_pkg::LevelW-1:0];
			ltd_pkg::REG_LEAK_PRESSED: touch_cfg.leak_pressed = value[ltd_pkg::LeakW-1:0];
			ltd_pkg::REG_LEAK_RELEASED: touch_cfg.leak_released = value[ltd_pkg::LeakW-1:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input logic [31:0] diff_thr, input logic [47:0] press_thr,
			input logic [15:0] leak_p, input logic [15:0] leak_r);
		write_reg(ltd_pkg::REG_DIFF_THRESHOLD, {32'd0, diff_thr});
		write_reg(ltd_pkg::REG_PRESS_THRESHOLD, {{16{press_thr[47]}}, press_thr});
		write_reg(ltd_pkg::REG_LEAK_PRESSED, {48'd0, leak_p});
		write_reg(ltd_pkg::REG_LEAK_RELEASED, {48'd0, leak_r});
	endtask

	task automatic randomize_config();
		logic [31:0] diff_thr;
		logic [47:0] press_thr;
		logic [63:0] wide;
		logic [15:0] leak_p;
		logic [15:0] leak_r;
		case ($urandom_range(9))
			0: diff_thr = '0;
			1: diff_thr = '1;
			2: diff_thr = $urandom();
			default: diff_thr = $urandom_range(0, 4000);
		endcase
		wide = {$urandom(), $urandom()};
		case ($urandom_range(9))
			0: press_thr = wide[47:0];
			1: press_thr = 48'h8000_0000_0000;
			2: press_thr = 48'h7FFF_FFFF_FFFF;
			default: press_thr = 48'(longint'($urandom_range(0, 600000)) - 200000);
		endcase
		leak_p = ($urandom_range(7) == 0) ? 16'hFFFF : 16'($urandom());
		leak_r = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom());
		set_config(diff_thr, press_thr, leak_p, leak_r);
	endtask

	// baseline with noise, stepped up and down like a finger landing and lifting
	task automatic send_touch_run(input int count);
		int base;
		int lvl;
		int held;
		int v;
		base = $urandom_range(0, 65535);
		lvl = base;
		held = 0;
		repeat (count) begin
			if (held == 0) begin
				case ($urandom_range(4))
					0: lvl = base;
					1: lvl = base + int'($urandom_range(0, 6000));
					2: lvl = base - int'($urandom_range(0, 6000));
					3: lvl = $urandom_range(0, 65535);
					default: lvl = base + int'($urandom_range(0, 400)) - 200;
				endcase
				held = $urandom_range(3, 25);
			end
			held--;
			v = lvl + int'($urandom_range(0, 64)) - 32;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			if ($urandom_range(9) == 0)
				v = $urandom_range(0, 65535);
			send_sample(16'(v));
		end
	endtask

	task automatic test_reset_defaults();
		send_sample(16'h8000);
		repeat (3) send_sample(16'hFFFF);
		repeat (3) send_sample(16'h0000);
		send_sample(16'hAAAA);
		send_sample(16'h5555);
		send_sample(16'h0001);
		send_sample(16'hFFFE);
		send_sample(16'h8000);
		drain_results();
	endtask

	task automatic test_register_extremes();
		// negative threshold: a level of zero already counts as pressed
		set_config('1, 48'h8000_0000_0000, 16'h0000, 16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		drain_results();
		set_config('0, 48'h7FFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		drain_results();
		set_config('0, 48'h0, 16'h0000, 16'h0000);
		send_sample(16'hFFFF);
		send_sample(16'h0000);
		send_sample(16'h0000);
		send_sample(16'hFFFF);
		drain_results();
	endtask

	task automatic test_random_phase(input int idle_pct, input int stall_pct,
			input int items);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		for (int done = 0; done < items; done += 50) begin
			randomize_config();
			send_touch_run(50);
			drain_results();
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	task automatic test_output_hold_off();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(32'd655, 48'd65536, 16'd58982, 16'd58982);
		hold_req = 1;
		send_touch_run(60);
		drain_results();
	endtask

	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HoldCycles;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		touch_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (touch_results_due.size() == 0) begin
				report_mismatch("unexpected result beat", m_tdata[63:0], '0);
			end else begin
				want = touch_results_due.pop_front();
				if (m_tuser[0] !== want.pressed)
					report_mismatch("pressed", 64'(m_tuser[0]), 64'(want.pressed));
				if (m_tdata[32:0] !== want.avg_delta)
					report_mismatch("avg_delta", 64'(m_tdata[32:0]), 64'(want.avg_delta));
				if (m_tdata[80:33] !== want.level)
					report_mismatch("integrator_level", 64'(m_tdata[80:33]),
						64'(want.level));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("leaky_integrator_touch_detector_top test failed");
			$finish;
		end
	end

	initial begin
		touch_cfg.diff_threshold = ltd_pkg::DIFF_THRESHOLD_RST;
		touch_cfg.press_threshold = ltd_pkg::PRESS_THRESHOLD_RST;
		touch_cfg.leak_pressed = ltd_pkg::LEAK_PRESSED_RST;
		touch_cfg.leak_released = ltd_pkg::LEAK_RELEASED_RST;
		avg_now = 0;
		avg_prev = 0;
		integ_leaked = 0;
		seeded = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_register_extremes();
		test_random_phase(0, 0, 200);
		test_random_phase(63, 0, 200);
		test_random_phase(0, 63, 200);
		test_random_phase(30, 30, 200);
		test_output_hold_off();

		if (mismatches == 0 && touch_results_due.size() == 0)
			$display("leaky_integrator_touch_detector_top test passed");
		else
			$display("leaky_integrator_touch_detector_top test failed");
		$finish;
	end

endmodule
